/* hdl/phd_pkg.sv */
// shared constants, codes and helper functions of the proximity haptic driver
`default_nettype none

package phd_pkg;

	localparam int DIST_W     = 16;
	localparam int LEVEL_W    = 7;
	localparam int DUTY_W     = 8;
	localparam int TIME_W     = 32;
	localparam int OPCODE_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = DIST_W + LEVEL_W;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_DIST = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STOP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WARNING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd4;

	// register reset values
	localparam logic [DIST_W-1:0]  WARNING_RST = 16'd2000;
	localparam logic [DIST_W-1:0]  DANGER_RST  = 16'd500;
	localparam logic [LEVEL_W-1:0] MIN_RST     = 7'd20;
	localparam logic [LEVEL_W-1:0] MAX_RST     = 7'd100;
	localparam logic [TIME_W-1:0]  PERIOD_RST  = 32'd200;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

	// reciprocal of 100 scaled by 2^19, exact for all duty products
	localparam int            RECIP_SHIFT = 19;
	localparam logic [12:0]   RECIP_100   = 13'd5243;

	function automatic logic [LEVEL_W-1:0] clamp_pct(input logic [LEVEL_W-1:0] v);
		return (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

	// level * 255 / 100, truncated
	function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
		logic [14:0] x;
		logic [27:0] p;
		x = {level, 8'd0} - 15'(level);
		p = 28'(x) * 28'(RECIP_100);
		return p[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
	endfunction

endpackage

`default_nettype wire

/* hdl/phd_if.sv */
// item channels of the proximity haptic driver
`default_nettype none

interface phd_in_if;
	import phd_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DIST_W-1:0]   left_dist_mm;
	logic [DIST_W-1:0]   right_dist_mm;

	modport source(output valid, output opcode, output left_dist_mm, output right_dist_mm,
		input ready);
	modport sink(input valid, input opcode, input left_dist_mm, input right_dist_mm,
		output ready);
endinterface

interface phd_out_if;
	import phd_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] left_duty;
	logic              left_drive;
	logic              left_pulse_mode;
	logic [DUTY_W-1:0] right_duty;
	logic              right_drive;
	logic              right_pulse_mode;

	modport source(output valid, output left_duty, output left_drive, output left_pulse_mode,
		output right_duty, output right_drive, output right_pulse_mode, input ready);
	modport sink(input valid, input left_duty, input left_drive, input left_pulse_mode,
		input right_duty, input right_drive, input right_pulse_mode, output ready);
endinterface

`default_nettype wire

/* hdl/proximity_haptic_driver.sv */
// proximity haptic driver: two motor sides driven from distances and millisecond ticks
// one item at a time; a steady side runs a bit-serial multiply and then a restoring divide
// on one shared unit, sides one after the other; the next item is taken while the previous
// result waits at the output
// arst_n clears time, side state and registers to their defaults; no clearing pass
`default_nettype none

module proximity_haptic_driver import phd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	phd_in_if.sink                     in_ch,
	phd_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_TICK,
		ST_MUL,
		ST_DIV,
		ST_LEVEL,
		ST_OUT
	} state_t;

	localparam logic [2:0] LAST_STEP = 3'(LEVEL_W - 1);

	state_t state_q;

	logic [DIST_W-1:0]  warn_q, danger_q;
	logic [LEVEL_W-1:0] min_q, max_q;
	logic [TIME_W-1:0]  period_q;

	logic [OPCODE_W-1:0] op_q;
	logic [DIST_W-1:0]   dist_q [2];
	logic                sd_q;

	logic [TIME_W-1:0]  now_q;
	logic               pulsing_q [2];
	logic               phase_q   [2];
	logic [TIME_W-1:0]  last_q    [2];
	logic [DUTY_W-1:0]  duty_q    [2];
	logic               drive_q   [2];
	logic [LEVEL_W-1:0] plevel_q  [2];
	logic [TIME_W-1:0]  pper_q    [2];

	logic [PROD_W-1:0]  mcand_q, prod_q;
	logic [LEVEL_W-1:0] mult_q, dq_q;
	logic [DIST_W-1:0]  rem_q;
	logic               neg_q;
	logic [2:0]         cnt_q;

	logic               out_valid_q;
	logic [DUTY_W-1:0]  out_duty_q [2];
	logic               out_drive_q [2];
	logic               out_pulse_q [2];

	// side step helpers
	logic [DIST_W-1:0]  d_cur;
	logic [7:0]         diff;
	logic [LEVEL_W-1:0] diff_mag;
	logic [TIME_W-1:0]  elapsed;
	logic               due;
	logic [PROD_W-1:0]  prod_nx;
	logic [DIST_W-1:0]  den;
	logic [DIST_W:0]    trial;
	logic               qbit;
	logic [8:0]         lvl;
	logic [LEVEL_W-1:0] lvl_clamped;
	logic               out_free;
	state_t             side_next;

	assign d_cur    = dist_q[sd_q];
	assign diff     = {1'b0, max_q} - {1'b0, min_q};
	assign diff_mag = diff[7] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
	assign elapsed  = now_q - last_q[sd_q];
	assign due      = pulsing_q[sd_q] && (elapsed >= pper_q[sd_q]);
	assign prod_nx  = prod_q + (mult_q[0] ? mcand_q : '0);
	assign den      = warn_q - danger_q;
	assign trial    = {rem_q, dq_q[LEVEL_W-1]};
	assign qbit     = trial >= {1'b0, den};

	// floor of min + signed quotient; a negative slope rounds toward minus infinity
	always_comb begin
		if (neg_q)
			lvl = {2'b00, min_q} - {2'b00, dq_q} - {8'd0, (rem_q != '0)};
		else
			lvl = {2'b00, min_q} + {2'b00, dq_q};
		if (lvl[8])
			lvl_clamped = '0;
		else if (lvl[7:0] > {1'b0, LEVEL_MAX})
			lvl_clamped = LEVEL_MAX;
		else
			lvl_clamped = lvl[LEVEL_W-1:0];
	end

	always_comb begin
		if (sd_q)
			side_next = ST_OUT;
		else if (op_q == OP_TICK)
			side_next = ST_TICK;
		else
			side_next = ST_DIST;
	end

	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready             = (state_q == ST_IDLE);
	assign out_ch.valid            = out_valid_q;
	assign out_ch.left_duty        = out_duty_q[0];
	assign out_ch.left_drive       = out_drive_q[0];
	assign out_ch.left_pulse_mode  = out_pulse_q[0];
	assign out_ch.right_duty       = out_duty_q[1];
	assign out_ch.right_drive      = out_drive_q[1];
	assign out_ch.right_pulse_mode = out_pulse_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_q   <= WARNING_RST;
			danger_q <= DANGER_RST;
			min_q    <= MIN_RST;
			max_q    <= MAX_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WARNING: warn_q   <= cfg_data[DIST_W-1:0];
				REG_DANGER:  danger_q <= cfg_data[DIST_W-1:0];
				REG_MIN:     min_q    <= cfg_data[LEVEL_W-1:0];
				REG_MAX:     max_q    <= cfg_data[LEVEL_W-1:0];
				REG_PERIOD:  period_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath registers of the item, the shared multiply/divide unit and the output
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			dist_q[0] <= in_ch.left_dist_mm;
			dist_q[1] <= in_ch.right_dist_mm;
		end
		if (state_q == ST_DIST) begin
			mcand_q <= PROD_W'(warn_q - d_cur);
			mult_q  <= diff_mag;
			neg_q   <= diff[7];
			prod_q  <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q  <= prod_nx;
			mcand_q <= mcand_q << 1;
			mult_q  <= mult_q >> 1;
			if (cnt_q == LAST_STEP) begin
				// high part is below the divisor since the quotient fits the level width
				rem_q <= prod_nx[PROD_W-1:LEVEL_W];
				dq_q  <= prod_nx[LEVEL_W-1:0];
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= qbit ? DIST_W'(trial - {1'b0, den}) : trial[DIST_W-1:0];
			dq_q  <= {dq_q[LEVEL_W-2:0], qbit};
		end
		if (state_q == ST_OUT && out_free) begin
			for (int s = 0; s < 2; s++) begin
				out_duty_q[s]  <= duty_q[s];
				out_drive_q[s] <= drive_q[s];
				out_pulse_q[s] <= pulsing_q[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DIST;
			sd_q        <= 1'b0;
			cnt_q       <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				pulsing_q[s] <= 1'b0;
				phase_q[s]   <= 1'b0;
				last_q[s]    <= '0;
				duty_q[s]    <= '0;
				drive_q[s]   <= 1'b0;
				plevel_q[s]  <= '0;
				pper_q[s]    <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						op_q <= in_ch.opcode;
						sd_q <= 1'b0;
						unique case (in_ch.opcode)
							OP_DIST: state_q <= ST_DIST;
							OP_TICK: begin
								now_q   <= now_q + 1'b1;
								state_q <= ST_TICK;
							end
							OP_STOP: begin
								for (int s = 0; s < 2; s++) begin
									pulsing_q[s] <= 1'b0;
									duty_q[s]    <= '0;
									drive_q[s]   <= 1'b0;
								end
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_DIST: begin
					cnt_q <= '0;
					if (d_cur < danger_q) begin
						// outputs keep their values until the next toggle
						pulsing_q[sd_q] <= 1'b1;
						plevel_q[sd_q]  <= clamp_pct(max_q);
						pper_q[sd_q]    <= period_q;
						state_q         <= side_next;
						sd_q            <= 1'b1;
					end else if (d_cur < warn_q) begin
						state_q <= ST_MUL;
					end else begin
						pulsing_q[sd_q] <= 1'b0;
						duty_q[sd_q]    <= '0;
						drive_q[sd_q]   <= 1'b0;
						state_q         <= side_next;
						sd_q            <= 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_q == LAST_STEP) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == LAST_STEP) begin
						cnt_q   <= '0;
						state_q <= ST_LEVEL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LEVEL: begin
					pulsing_q[sd_q] <= 1'b0;
					duty_q[sd_q]    <= duty_of(lvl_clamped);
					drive_q[sd_q]   <= (lvl_clamped != '0);
					state_q         <= side_next;
					sd_q            <= 1'b1;
				end
				ST_TICK: begin
					if (due) begin
						last_q[sd_q]  <= now_q;
						phase_q[sd_q] <= !phase_q[sd_q];
						if (!phase_q[sd_q]) begin
							duty_q[sd_q]  <= duty_of(plevel_q[sd_q]);
							drive_q[sd_q] <= (plevel_q[sd_q] != '0);
						end else begin
							duty_q[sd_q]  <= '0;
							drive_q[sd_q] <= 1'b0;
						end
					end
					state_q <= side_next;
					sd_q    <= 1'b1;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* verif/proximity_haptic_driver_tb.sv */
// testbench of the proximity haptic driver: predicted motor outputs checked against every result
`timescale 1ns / 100ps

module proximity_haptic_driver_tb;
	import phd_pkg::*;

	// opcode that the block ignores
	localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd3;

	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_PRINTS    = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 145;

	typedef struct packed {
		logic [1:0][DUTY_W-1:0] duty;
		logic [1:0]             drive;
		logic [1:0]             pulse;
	} motor_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	phd_in_if  in_ch ();
	phd_out_if out_ch ();

	proximity_haptic_driver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies
	logic [DIST_W-1:0]  warn_mm;
	logic [DIST_W-1:0]  danger_mm;
	logic [LEVEL_W-1:0] min_lvl;
	logic [LEVEL_W-1:0] max_lvl;
	logic [TIME_W-1:0]  period_ms;

	// motor state, index 0 left, 1 right
	logic [TIME_W-1:0]  now_ms;
	logic               pulsing     [2];
	logic               phase_on    [2];
	logic [TIME_W-1:0]  last_toggle [2];
	logic [DUTY_W-1:0]  duty        [2];
	logic               drive       [2];
	logic [LEVEL_W-1:0] pulse_lvl   [2];
	logic [TIME_W-1:0]  pulse_per   [2];

	motor_out_t pending_outputs [$];

	int  mismatches;
	int  items_sent;
	int  results_checked;
	int  settings_used;
	int  toggles_predicted;
	bit  no_idle;
	int  hold_ask;
	int  hold_seen;
	int  hold_left;
	int  sink_gap;

	string side_name [2] = '{"left", "right"};

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#10000000;
		$display("run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(40, 120);
	endfunction

	function automatic logic [DUTY_W-1:0] pct_to_duty(input int unsigned lvl);
		return DUTY_W'(lvl * 255 / 100);
	endfunction

	function automatic void set_side_level(input int s, input int lvl);
		if (lvl > 0) begin
			duty[s]  = pct_to_duty(lvl);
			drive[s] = 1'b1;
		end else begin
			duty[s]  = '0;
			drive[s] = 1'b0;
		end
	endfunction

	function automatic void stop_side(input int s);
		pulsing[s] = 1'b0;
		duty[s]    = '0;
		drive[s]   = 1'b0;
	endfunction

	// linear ramp from min at warning to max at danger, floored, clamped to 0..100
	function automatic int graded_level(input logic [DIST_W-1:0] range_mm);
		longint num;
		longint den;
		longint lvl;
		num = (longint'(warn_mm) - longint'(range_mm)) * (longint'(max_lvl) - longint'(min_lvl));
		den = longint'(warn_mm) - longint'(danger_mm);
		if (num >= 0)
			lvl = longint'(min_lvl) + num / den;
		else
			lvl = longint'(min_lvl) - ((-num) + den - 1) / den;
		if (lvl < 0)
			lvl = 0;
		if (lvl > 100)
			lvl = 100;
		return int'(lvl);
	endfunction

	task automatic predict_motor_outputs(input logic [OPCODE_W-1:0] op,
		input logic [DIST_W-1:0] left_mm, input logic [DIST_W-1:0] right_mm);
		logic [DIST_W-1:0] range_mm [2];
		motor_out_t        res;
		int                s;
		range_mm[0] = left_mm;
		range_mm[1] = right_mm;
		case (op)
			OP_DIST: begin
				for (s = 0; s < 2; s++) begin
					if (range_mm[s] < danger_mm) begin
						// outputs stay as they were until the next toggle
						pulsing[s]   = 1'b1;
						pulse_lvl[s] = (max_lvl > LEVEL_MAX) ? LEVEL_MAX : max_lvl;
						pulse_per[s] = period_ms;
					end else if (range_mm[s] < warn_mm) begin
						pulsing[s] = 1'b0;
						set_side_level(s, graded_level(range_mm[s]));
					end else begin
						stop_side(s);
					end
				end
			end
			OP_TICK: begin
				now_ms = now_ms + 1'b1;
				for (s = 0; s < 2; s++) begin
					if (pulsing[s] && (now_ms - last_toggle[s]) >= pulse_per[s]) begin
						last_toggle[s] = now_ms;
						phase_on[s]    = ~phase_on[s];
						set_side_level(s, phase_on[s] ? int'(pulse_lvl[s]) : 0);
						toggles_predicted++;
					end
				end
			end
			OP_STOP: begin
				stop_side(0);
				stop_side(1);
			end
			default: begin
			end
		endcase
		for (s = 0; s < 2; s++) begin
			res.duty[s]  = duty[s];
			res.drive[s] = drive[s];
			res.pulse[s] = pulsing[s];
		end
		pending_outputs.push_back(res);
	endtask

	task automatic send_item(input logic [OPCODE_W-1:0] op,
		input logic [DIST_W-1:0] left_mm, input logic [DIST_W-1:0] right_mm);
		int gap;
		gap = no_idle ? 0 : idle_length();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.opcode        <= op;
		in_ch.left_dist_mm  <= left_mm;
		in_ch.right_dist_mm <= right_mm;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_motor_outputs(op, left_mm, right_mm);
		items_sent++;
	endtask

	task automatic wait_for_results();
		int n;
		in_ch.valid <= 1'b0;
		n = 0;
		@(posedge clk);
		while (pending_outputs.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_outputs.size() != 0) begin
			report_mismatch("results never delivered", pending_outputs.size(), 0);
			pending_outputs.delete();
		end
	endtask

	// block is idle here: every pending result has arrived
	task automatic write_thresholds(input logic [DIST_W-1:0] warn, input logic [DIST_W-1:0] danger,
		input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi, input logic [TIME_W-1:0] per);
		logic [CFG_IDX_W-1:0]  idx  [5];
		logic [CFG_DATA_W-1:0] data [5];
		int                    i;
		idx  = '{REG_WARNING, REG_DANGER, REG_MIN, REG_MAX, REG_PERIOD};
		data = '{CFG_DATA_W'(warn), CFG_DATA_W'(danger), CFG_DATA_W'(lo), CFG_DATA_W'(hi),
			CFG_DATA_W'(per)};
		for (i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= data[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		warn_mm   = warn;
		danger_mm = danger;
		min_lvl   = lo;
		max_lvl   = hi;
		period_ms = per;
		settings_used++;
	endtask

	// distances aimed around the current thresholds, plus full-range values
	function automatic logic [DIST_W-1:0] random_distance();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return DIST_W'($urandom);
			2, 3: begin
				if (danger_mm == 0)
					return DIST_W'($urandom);
				return DIST_W'($urandom_range(0, int'(danger_mm) - 1));
			end
			4, 5, 6: begin
				if (warn_mm <= danger_mm)
					return DIST_W'($urandom);
				return DIST_W'($urandom_range(int'(danger_mm), int'(warn_mm) - 1));
			end
			7: return DIST_W'(int'(danger_mm) + int'($urandom_range(0, 2)) - 1);
			8: return DIST_W'(int'(warn_mm) + int'($urandom_range(0, 2)) - 1);
			default: return DIST_W'($urandom_range(int'(warn_mm), 65535));
		endcase
	endfunction

	task automatic send_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_item(OP_TICK, DIST_W'($urandom), DIST_W'($urandom));
		else if (r < 85)
			send_item(OP_DIST, random_distance(), random_distance());
		else if (r < 95)
			send_item(OP_STOP, DIST_W'($urandom), DIST_W'($urandom));
		else
			send_item(OP_IDLE, DIST_W'($urandom), DIST_W'($urandom));
	endtask

	// reset thresholds: pulse, steady, stop, tick, ignored item, stop item
	task automatic test_reset_defaults();
		send_item(OP_DIST, 16'd0, 16'd65535);
		send_item(OP_DIST, 16'd500, 16'd1999);
		send_item(OP_DIST, 16'd499, 16'd2000);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_IDLE, 16'hffff, 16'hffff);
		send_item(OP_STOP, 16'd0, 16'd0);
		wait_for_results();
	endtask

	// period zero toggles on every tick; max level above 100 is clamped
	task automatic test_pulse_toggling();
		write_thresholds(16'd2000, 16'd500, 7'd0, 7'd127, 32'd0);
		send_item(OP_DIST, 16'd0, 16'd499);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_DIST, 16'd1000, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_STOP, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		wait_for_results();
		write_thresholds(16'd2000, 16'd500, 7'd20, 7'd100, 32'd3);
		send_item(OP_DIST, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		wait_for_results();
	endtask

	// falling ramp, no graded zone, zero thresholds, zero pulse level, longest period
	task automatic test_level_extremes();
		write_thresholds(16'd65535, 16'd0, 7'd100, 7'd0, 32'hffff_ffff);
		send_item(OP_DIST, 16'd0, 16'd65534);
		send_item(OP_DIST, 16'd65535, 16'd32768);
		send_item(OP_TICK, 16'd0, 16'd0);
		wait_for_results();
		write_thresholds(16'd0, 16'd65535, 7'd20, 7'd100, 32'hffff_ffff);
		send_item(OP_DIST, 16'd65534, 16'd65535);
		send_item(OP_TICK, 16'd0, 16'd0);
		wait_for_results();
		write_thresholds(16'd0, 16'd0, 7'd127, 7'd127, 32'd200);
		send_item(OP_DIST, 16'd0, 16'd0);
		wait_for_results();
		write_thresholds(16'd2000, 16'd500, 7'd20, 7'd0, 32'd0);
		send_item(OP_DIST, 16'd0, 16'd0);
		send_item(OP_TICK, 16'd0, 16'd0);
		wait_for_results();
	endtask

	// output held off while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		int i;
		write_thresholds(16'd3000, 16'd1000, 7'd10, 7'd90, 32'd1);
		no_idle = 1'b1;
		hold_ask <= hold_ask + 1;
		for (i = 0; i < 40; i++)
			send_random_item();
		no_idle = 1'b0;
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int                 phase;
		int                 i;
		int                 r;
		logic [DIST_W-1:0]  warn;
		logic [DIST_W-1:0]  danger;
		logic [LEVEL_W-1:0] lo;
		logic [LEVEL_W-1:0] hi;
		logic [TIME_W-1:0]  per;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			warn   = ($urandom_range(0, 9) < 8) ? DIST_W'($urandom_range(0, 6000))
				: DIST_W'($urandom);
			danger = ($urandom_range(0, 9) < 8) ? DIST_W'($urandom_range(0, int'(warn)))
				: DIST_W'($urandom);
			lo = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(101, 127))
				: LEVEL_W'($urandom_range(0, 100));
			hi = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(101, 127))
				: LEVEL_W'($urandom_range(0, 100));
			r = $urandom_range(0, 99);
			if (r < 50)
				per = $urandom_range(0, 6);
			else if (r < 80)
				per = $urandom_range(7, 60);
			else if (r < 95)
				per = 32'd200;
			else
				per = $urandom;
			write_thresholds(warn, danger, lo, hi, per);
			no_idle = (phase % 4 == 3);
			for (i = 0; i < PHASE_ITEMS; i++)
				send_random_item();
			no_idle = 1'b0;
			wait_for_results();
		end
	endtask

	always @(posedge clk) begin : sink_pacing
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else if (sink_gap > 0) begin
			out_ch.ready <= 1'b0;
			sink_gap--;
		end else begin
			out_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				sink_gap = idle_length();
		end
	end

	always @(posedge clk) begin : check_results
		motor_out_t got;
		motor_out_t want;
		int         s;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.duty[0]  = out_ch.left_duty;
			got.drive[0] = out_ch.left_drive;
			got.pulse[0] = out_ch.left_pulse_mode;
			got.duty[1]  = out_ch.right_duty;
			got.drive[1] = out_ch.right_drive;
			got.pulse[1] = out_ch.right_pulse_mode;
			if (pending_outputs.size() == 0) begin
				report_mismatch("result with no item pending", got, 0);
			end else begin
				want = pending_outputs.pop_front();
				for (s = 0; s < 2; s++) begin
					if (got.duty[s] !== want.duty[s])
						report_mismatch({side_name[s], " duty"}, got.duty[s], want.duty[s]);
					if (got.drive[s] !== want.drive[s])
						report_mismatch({side_name[s], " drive"}, got.drive[s], want.drive[s]);
					if (got.pulse[s] !== want.pulse[s])
						report_mismatch({side_name[s], " pulse mode"}, got.pulse[s],
							want.pulse[s]);
				end
				results_checked++;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		in_ch.valid         = 1'b0;
		in_ch.opcode        = OP_DIST;
		in_ch.left_dist_mm  = '0;
		in_ch.right_dist_mm = '0;
		out_ch.ready        = 1'b0;
		warn_mm             = WARNING_RST;
		danger_mm           = DANGER_RST;
		min_lvl             = MIN_RST;
		max_lvl             = MAX_RST;
		period_ms           = PERIOD_RST;
		now_ms              = '0;
		for (int s = 0; s < 2; s++) begin
			pulsing[s]     = 1'b0;
			phase_on[s]    = 1'b0;
			last_toggle[s] = '0;
			duty[s]        = '0;
			drive[s]       = 1'b0;
			pulse_lvl[s]   = '0;
			pulse_per[s]   = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_pulse_toggling();
		test_level_extremes();
		test_output_backpressure();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items over %0d register settings, %0d results checked",
			items_sent, settings_used + 1, results_checked);
		$display("predicted %0d pulse phase toggles, one output hold-off of %0d cycles",
			toggles_predicted, HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
hdl/phd_pkg.sv
hdl/phd_if.sv
hdl/proximity_haptic_driver.sv
verif/proximity_haptic_driver_tb.sv
